### rtl/lpdt_pkg.sv
// ----------------------------------------------------------------------------
// lpdt_pkg
// Shared types and constants for the length-prefixed deframer with tokens.
// ----------------------------------------------------------------------------
package lpdt_pkg;

  localparam int HEADER_BYTES         = 8;
  localparam int HDR_IDX_W            = $clog2(HEADER_BYTES);
  localparam int HDR_STORE_W          = 8 * (HEADER_BYTES - 1);
  localparam int BODY_LEN_W           = 17;
  localparam int TOK_W                = 5;
  localparam int POOL_W               = 6;
  localparam int DEF_MAX_BODY_BYTES   = 65536;
  localparam int DEF_MAX_FRAME_TOKENS = 16;

  typedef enum logic [1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_TOKENS = 2'd1,
    FUNC_TRUNC  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERSIZE  = 3'd1,
    ERR_TOKENS    = 3'd2,
    ERR_SHORTFALL = 3'd3,
    ERR_TRUNC     = 3'd4
  } err_e_t;

  localparam logic CFG_IDX_MAX_BODY   = 1'b0;
  localparam logic CFG_IDX_MAX_TOKENS = 1'b1;

  typedef struct packed {
    kind_e_t          kind;
    logic [7:0]       body_byte;
    logic             frame_last;
    logic [TOK_W-1:0] frame_tokens;
    err_e_t           error_code;
  } res_t;

endpackage

### rtl/lpdt_step.sv
// ----------------------------------------------------------------------------
// lpdt_step
// Header parse, limit checks, body count and token pool; one transaction
// per cycle, result produced in the same cycle as the accept.
// ----------------------------------------------------------------------------
module lpdt_step import lpdt_pkg::*; #(
  parameter int MAX_BODY_BYTES   = DEF_MAX_BODY_BYTES,
  parameter int MAX_FRAME_TOKENS = DEF_MAX_FRAME_TOKENS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [1:0]            func,
  input  logic [7:0]            data_byte,
  input  logic [POOL_W-1:0]     arrived_tokens,
  input  logic [BODY_LEN_W-1:0] max_body_bytes,
  input  logic [TOK_W-1:0]      max_frame_tokens,
  output logic                  res_valid,
  output res_t                  res
);

  logic [HDR_STORE_W-1:0] header_r, header_nxt;
  logic [HDR_IDX_W-1:0]   hdr_idx_r, hdr_idx_nxt;
  logic                   in_body_r, in_body_nxt;
  logic [BODY_LEN_W-1:0]  body_rem_r, body_rem_nxt;
  logic [TOK_W-1:0]       need_r, need_nxt;
  logic [POOL_W-1:0]      pool_r, pool_nxt;
  err_e_t                 sticky_r, sticky_nxt;

  logic [BODY_LEN_W-1:0]  body_lim;
  logic [TOK_W-1:0]       tok_lim;
  logic [31:0]            hdr_len;
  logic [31:0]            hdr_count;
  logic [POOL_W:0]        pool_sum;

  // effective limits: register clamped by the build-time ceiling
  assign body_lim = ({15'd0, max_body_bytes} < 32'(MAX_BODY_BYTES)) ?
                    max_body_bytes : BODY_LEN_W'(MAX_BODY_BYTES);
  assign tok_lim  = ({24'd0, 3'd0, max_frame_tokens} < 32'(MAX_FRAME_TOKENS)) ?
                    max_frame_tokens : TOK_W'(MAX_FRAME_TOKENS);

  // final header byte arrives live; earlier seven are stored
  assign hdr_len   = header_r[31:0];
  assign hdr_count = {data_byte, header_r[HDR_STORE_W-1:32]};
  assign pool_sum  = {1'b0, pool_r} + {1'b0, arrived_tokens};

  always_comb begin
    header_nxt  = header_r;
    hdr_idx_nxt = hdr_idx_r;
    in_body_nxt = in_body_r;
    body_rem_nxt = body_rem_r;
    need_nxt    = need_r;
    pool_nxt    = pool_r;
    sticky_nxt  = sticky_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_BODY, body_byte: 8'd0, frame_last: 1'b0,
                    frame_tokens: '0, error_code: ERR_NONE};

    if (acc && (sticky_r == ERR_NONE)) begin
      case (func_e_t'(func))
        FUNC_TRUNC: begin
          sticky_nxt     = ERR_TRUNC;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC;
        end
        FUNC_TOKENS: begin
          if (pool_sum > {1'b0, tok_lim, 1'b0}) begin
            sticky_nxt     = ERR_TOKENS;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TOKENS;
          end else begin
            pool_nxt = pool_sum[POOL_W-1:0];
          end
        end
        FUNC_DATA: begin
          if (!in_body_r) begin
            if (hdr_idx_r != HDR_IDX_W'(HEADER_BYTES - 1)) begin
              header_nxt[hdr_idx_r*8 +: 8] = data_byte;
              hdr_idx_nxt = hdr_idx_r + 1'b1;
            end else begin
              hdr_idx_nxt = '0;
              if (hdr_len > {15'd0, body_lim}) begin
                sticky_nxt     = ERR_OVERSIZE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_OVERSIZE;
              end else if (hdr_count > {27'd0, tok_lim}) begin
                sticky_nxt     = ERR_TOKENS;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TOKENS;
              end else if (hdr_len == 32'd0) begin
                res_valid = 1'b1;
                if (pool_r < {1'b0, hdr_count[TOK_W-1:0]}) begin
                  sticky_nxt     = ERR_SHORTFALL;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_SHORTFALL;
                end else begin
                  pool_nxt         = pool_r - {1'b0, hdr_count[TOK_W-1:0]};
                  res.kind         = KIND_EMPTY;
                  res.frame_last   = 1'b1;
                  res.frame_tokens = hdr_count[TOK_W-1:0];
                end
              end else begin
                in_body_nxt  = 1'b1;
                body_rem_nxt = hdr_len[BODY_LEN_W-1:0];
                need_nxt     = hdr_count[TOK_W-1:0];
              end
            end
          end else begin
            res_valid = 1'b1;
            if (body_rem_r > BODY_LEN_W'(1)) begin
              body_rem_nxt  = body_rem_r - 1'b1;
              res.body_byte = data_byte;
            end else if (pool_r < {1'b0, need_r}) begin
              sticky_nxt     = ERR_SHORTFALL;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SHORTFALL;
            end else begin
              pool_nxt         = pool_r - {1'b0, need_r};
              in_body_nxt      = 1'b0;
              body_rem_nxt     = '0;
              need_nxt         = '0;
              res.body_byte    = data_byte;
              res.frame_last   = 1'b1;
              res.frame_tokens = need_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    header_r <= header_nxt;
    if (!rst_n) begin
      hdr_idx_r  <= '0;
      in_body_r  <= 1'b0;
      body_rem_r <= '0;
      need_r     <= '0;
      pool_r     <= '0;
      sticky_r   <= ERR_NONE;
    end else begin
      hdr_idx_r  <= hdr_idx_nxt;
      in_body_r  <= in_body_nxt;
      body_rem_r <= body_rem_nxt;
      need_r     <= need_nxt;
      pool_r     <= pool_nxt;
      sticky_r   <= sticky_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fail_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != ERR_NONE) |-> !res_valid)
    else $error("result produced after sticky error");
  a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_ERROR) |=> (sticky_r != ERR_NONE))
    else $error("error report did not latch sticky error");
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (body_rem_r != '0))
    else $error("body active with zero bytes remaining");
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r == ERR_NONE && $past(sticky_r) == ERR_NONE && $past(rst_n))
      |-> ({1'b0, pool_r} <= {1'b0, $past(tok_lim), 1'b0} || $past(pool_r) == pool_r))
    else $error("token pool exceeded twice the token limit");
`endif

endmodule

### rtl/lpdt_skid.sv
// ----------------------------------------------------------------------------
// lpdt_skid
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module lpdt_skid import lpdt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic space,
  input  logic pop_ready,
  output logic main_valid,
  output res_t main_res
);

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop        = main_v_r && pop_ready;
  assign space      = !skid_v_r;
  assign main_valid = main_v_r;
  assign main_res   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_res;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held with empty output register");
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("result pushed into full buffer");
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && pop_ready) |=> (main_v_r && !skid_v_r))
    else $error("skid entry did not move to output register");
`endif

endmodule

### rtl/length_prefixed_deframer_with_tokens_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer_with_tokens_core
// Length-prefixed frame deframer with side-band token accounting.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock while in_tready is high
// and registers each result into a two-entry output buffer. Each frame opens
// with an 8-byte header (little-endian 32-bit body length, then 32-bit token
// count); body bytes stream out without a frame store, the last one with tlast
// and the frame's token count. Token arrivals and truncation reports come in
// on the same channel, selected by in_tuser. Any violation (oversize body, too
// many tokens, pool overflow, shortfall at frame end, truncation) gives one
// error result and then the block swallows every input until reset. Rate is
// one transaction per cycle, set by the parse/count step; the buffer lets
// the input keep flowing into its second entry while out_tready is low, after
// which in_tready drops until that entry drains. Limits are clamped to the
// MAX_BODY_BYTES and MAX_FRAME_TOKENS ceilings; write them only while idle.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_with_tokens_core import lpdt_pkg::*; #(
  parameter int MAX_BODY_BYTES   = DEF_MAX_BODY_BYTES,
  parameter int MAX_FRAME_TOKENS = DEF_MAX_FRAME_TOKENS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [BODY_LEN_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,  // [7:0] data_byte, [13:8] arrived_tokens, pad
  input  logic [1:0]            in_tuser,  // [1:0] func
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata, // [7:0] body_byte, [12:8] frame_tokens,
                                           // [15:13] error_code
  output logic                  out_tlast, // frame_last
  output logic [1:0]            out_tuser  // [1:0] out_kind
);

  logic [BODY_LEN_W-1:0] max_body_r;
  logic [TOK_W-1:0]      max_tok_r;
  logic                  in_acc;
  logic                  res_valid;
  res_t                  res;
  res_t                  out_res;
  logic                  space;

  // limit registers; taken at face value, clamping happens in the step logic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= BODY_LEN_W'(DEF_MAX_BODY_BYTES);
      max_tok_r  <= TOK_W'(DEF_MAX_FRAME_TOKENS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MAX_BODY:   max_body_r <= cfg_wdata;
        CFG_IDX_MAX_TOKENS: max_tok_r  <= cfg_wdata[TOK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ready follows buffer space only, never the parse state
  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  lpdt_step #(
    .MAX_BODY_BYTES   (MAX_BODY_BYTES),
    .MAX_FRAME_TOKENS (MAX_FRAME_TOKENS)
  ) u_step (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (in_acc),
    .func             (in_tuser),
    .data_byte        (in_tdata[7:0]),
    .arrived_tokens   (in_tdata[13:8]),
    .max_body_bytes   (max_body_r),
    .max_frame_tokens (max_tok_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  lpdt_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .space      (space),
    .pop_ready  (out_tready),
    .main_valid (out_tvalid),
    .main_res   (out_res)
  );

  assign out_tdata = {out_res.error_code, out_res.frame_tokens, out_res.body_byte};
  assign out_tlast = out_res.frame_last;
  assign out_tuser = out_res.kind;

endmodule
